>>> design/dual_wheel_pi_speed_control_macros.svh
// assertion macros for the dual wheel pi speed controller checker
// expects clk and rst_n in the scope of use
`ifndef DUAL_WHEEL_PI_SPEED_CONTROL_MACROS_SVH
`define DUAL_WHEEL_PI_SPEED_CONTROL_MACROS_SVH

// same-cycle implication
`define DWPI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwpi assertion failed");

// next-cycle implication
`define DWPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwpi assertion failed");

`endif

>>> design/dwpi_pkg.sv
// shared types and constants of the dual wheel pi speed controller
// no dependencies
package dwpi_pkg;

    localparam int SPEED_W        = 11;
    localparam int COUNT_W        = 32;
    localparam int DUTY_W         = 12;
    localparam int SUM_W          = 13;
    localparam int PGAIN_W        = 9;
    localparam int IGAIN_W        = 8;
    localparam int LIMIT_W        = 12;
    localparam int SCALE_W        = 16;
    localparam int FRAC_BITS      = 20;
    localparam int PWM_BITS       = 12;
    localparam int PWM_MAX        = (1 << PWM_BITS) - 1;
    localparam int COUNT_BITS_DEF = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic signed [SPEED_W-1:0] FORCE_ZERO_SPEED = 11'sd320;

    localparam logic [PGAIN_W-1:0] PGAIN_RST = 9'd50;
    localparam logic [IGAIN_W-1:0] IGAIN_RST = 8'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 12'd500;
    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd25752;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN,
        REG_INTEGRAL_GAIN,
        REG_INTEGRAL_LIMIT,
        REG_COUNT_SCALE
    } cfg_reg_t;

    typedef struct packed {
        logic [PGAIN_W-1:0] prop_gain;
        logic [IGAIN_W-1:0] integral_gain;
        logic [LIMIT_W-1:0] integral_limit;
        logic [SCALE_W-1:0] count_scale;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ERR,
        ST_PROP,
        ST_INTG,
        ST_SUM,
        ST_DONE
    } state_t;

endpackage

>>> design/dwpi_cmd_if.sv
// command channel: speed commands and encoder counts of both wheels
// depends on dwpi_pkg
interface dwpi_cmd_if;
    import dwpi_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] right_speed;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [COUNT_W-1:0] right_count;
    logic signed [COUNT_W-1:0] left_count;

    modport source (
        output valid, right_speed, left_speed, right_count, left_count,
        input  ready
    );

    modport sink (
        input  valid, right_speed, left_speed, right_count, left_count,
        output ready
    );

endinterface

>>> design/dwpi_res_if.sv
// result channel: duty magnitude and reverse flag of both wheels
// depends on dwpi_pkg
interface dwpi_res_if;
    import dwpi_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] right_duty;
    logic [DUTY_W-1:0] left_duty;
    logic              right_reverse;
    logic              left_reverse;

    modport source (
        output valid, right_duty, left_duty, right_reverse, left_reverse,
        input  ready
    );

    modport sink (
        input  valid, right_duty, left_duty, right_reverse, left_reverse,
        output ready
    );

endinterface

>>> design/dwpi_cfg.sv
// configuration register file: gains, integral limit and count scale
// depends on dwpi_pkg
module dwpi_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [dwpi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dwpi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output dwpi_pkg::cfg_t                   cfg
);
    import dwpi_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= PGAIN_RST;
            cfg_reg.integral_gain  <= IGAIN_RST;
            cfg_reg.integral_limit <= LIMIT_RST;
            cfg_reg.count_scale    <= SCALE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:      cfg_reg.prop_gain      <= cfg_wdata[PGAIN_W-1:0];
                REG_INTEGRAL_GAIN:  cfg_reg.integral_gain  <= cfg_wdata[IGAIN_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_wdata[LIMIT_W-1:0];
                REG_COUNT_SCALE:    cfg_reg.count_scale    <= cfg_wdata[SCALE_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/dwpi_mul.sv
// shared signed by unsigned multiplier with registered product
// depends on dwpi_pkg
module dwpi_mul #(
    parameter int A_W    = dwpi_pkg::COUNT_BITS_DEF + 2,
    parameter int PROD_W = A_W + dwpi_pkg::SCALE_W + 1
) (
    input  logic                          clk,
    input  logic signed [A_W-1:0]         mul_a,
    input  logic [dwpi_pkg::SCALE_W-1:0]  mul_b,
    output logic signed [PROD_W-1:0]      prod
);
    import dwpi_pkg::*;

    logic signed [SCALE_W:0]   b_ext;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;

    assign b_ext     = signed'({1'b0, mul_b});
    assign prod_next = PROD_W'(mul_a) * PROD_W'(b_ext);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

>>> design/dwpi_seq.sv
// sequencer and per-wheel datapath: delta, error, clamped integral, drive
// depends on dwpi_pkg, dwpi_cmd_if, dwpi_res_if; drives the shared multiplier
module dwpi_seq #(
    parameter int COUNT_BITS = dwpi_pkg::COUNT_BITS_DEF,
    parameter int ERR_W      = COUNT_BITS + 2,
    parameter int PROD_W     = ERR_W + dwpi_pkg::SCALE_W + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dwpi_pkg::cfg_t                cfg,
    dwpi_cmd_if.sink                      cmd,
    dwpi_res_if.source                    res,
    output logic signed [ERR_W-1:0]       mul_a,
    output logic [dwpi_pkg::SCALE_W-1:0]  mul_b,
    input  logic signed [PROD_W-1:0]      prod
);
    import dwpi_pkg::*;

    localparam int SUM_EXT_W = ERR_W + 1;
    localparam int DRV_W     = PROD_W + 1;
    localparam int QHI_W     = PROD_W - FRAC_BITS;

    state_t state_reg, state_next;
    logic   wheel_reg, wheel_next;

    logic signed [SPEED_W-1:0]    speed_reg [2];
    logic [COUNT_BITS-1:0]        count_reg [2];
    logic [COUNT_BITS-1:0]        prev_reg  [2];
    logic signed [SUM_W-1:0]      sum_reg   [2];
    logic [DUTY_W-1:0]            duty_reg  [2];
    logic                         rev_reg   [2];
    logic signed [COUNT_BITS-1:0] delta_reg;
    logic signed [ERR_W-1:0]      err_reg;
    logic signed [PROD_W-1:0]     acc_reg;

    logic              res_valid_reg;
    logic [DUTY_W-1:0] res_right_duty_reg;
    logic [DUTY_W-1:0] res_left_duty_reg;
    logic              res_right_rev_reg;
    logic              res_left_rev_reg;

    logic                         accept;
    logic                         res_load;
    logic signed [SPEED_W-1:0]    speed_cur;
    logic [COUNT_BITS-1:0]        count_cur;
    logic signed [SUM_W-1:0]      sum_cur;
    logic signed [COUNT_BITS-1:0] delta_calc;
    logic signed [QHI_W-1:0]      q_hi;
    logic                         q_frac_nz;
    logic signed [ERR_W-1:0]      err_floor;
    logic signed [ERR_W-1:0]      err_corr;
    logic signed [ERR_W-1:0]      err_calc;
    logic signed [SUM_EXT_W-1:0]  sum_ext;
    logic signed [SUM_EXT_W-1:0]  lim_pos;
    logic signed [SUM_EXT_W-1:0]  lim_neg;
    logic signed [SUM_W-1:0]      sum_clamp;
    logic signed [DRV_W-1:0]      drive;
    logic signed [DRV_W-1:0]      drv_max;
    logic                         force_zero;
    logic [DUTY_W-1:0]            duty_calc;

    assign accept   = cmd.valid && cmd.ready;
    assign res_load = (state_reg == ST_DONE) && (!res_valid_reg || res.ready);

    assign speed_cur = speed_reg[wheel_reg];
    assign count_cur = count_reg[wheel_reg];
    assign sum_cur   = sum_reg[wheel_reg];

    // count delta wraps at the counter width
    assign delta_calc = signed'(count_cur - prev_reg[wheel_reg]);

    // error truncated toward zero
    assign q_hi      = prod[PROD_W-1:FRAC_BITS];
    assign q_frac_nz = |prod[FRAC_BITS-1:0];
    assign err_floor = ERR_W'(q_hi) - ERR_W'(delta_reg);
    assign err_corr  = {{(ERR_W-1){1'b0}}, (err_floor < 0) && q_frac_nz};
    assign err_calc  = err_floor + err_corr;

    // clamped integral
    assign sum_ext = SUM_EXT_W'(sum_cur) + SUM_EXT_W'(err_reg);
    assign lim_pos = signed'(SUM_EXT_W'(cfg.integral_limit));
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (sum_ext > lim_pos)
            sum_clamp = lim_pos[SUM_W-1:0];
        else if (sum_ext < lim_neg)
            sum_clamp = lim_neg[SUM_W-1:0];
        else
            sum_clamp = sum_ext[SUM_W-1:0];
    end

    // drive and duty
    assign drive      = DRV_W'(acc_reg) + DRV_W'(prod);
    assign drv_max    = DRV_W'(PWM_MAX);
    assign force_zero = (speed_cur == '0) || (speed_cur == FORCE_ZERO_SPEED);

    always_comb
    begin
        if (force_zero || drive < 0)
            duty_calc = '0;
        else if (drive > drv_max)
            duty_calc = drv_max[DUTY_W-1:0];
        else
            duty_calc = drive[DUTY_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        wheel_next = wheel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                    wheel_next = 1'b0;
                end
            end
            ST_LOAD: state_next = ST_ERR;
            ST_ERR:  state_next = ST_PROP;
            ST_PROP: state_next = ST_INTG;
            ST_INTG: state_next = ST_SUM;
            ST_SUM:
            begin
                if (!wheel_reg)
                begin
                    state_next = ST_LOAD;
                    wheel_next = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs: multiplier operands and handshake
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                mul_a = ERR_W'(speed_cur);
                mul_b = cfg.count_scale;
            end
            ST_PROP:
            begin
                mul_a = err_reg;
                mul_b = SCALE_W'(cfg.prop_gain);
            end
            ST_INTG:
            begin
                mul_a = ERR_W'(sum_cur);
                mul_b = SCALE_W'(cfg.integral_gain);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign cmd.ready         = (state_reg == ST_IDLE);
    assign res.valid         = res_valid_reg;
    assign res.right_duty    = res_right_duty_reg;
    assign res.left_duty     = res_left_duty_reg;
    assign res.right_reverse = res_right_rev_reg;
    assign res.left_reverse  = res_left_rev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wheel_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                prev_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            wheel_reg <= wheel_next;
            if (state_reg == ST_LOAD)
                prev_reg[wheel_reg] <= count_cur;
            if (state_reg == ST_PROP)
                sum_reg[wheel_reg] <= sum_clamp;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            speed_reg[0] <= cmd.right_speed;
            speed_reg[1] <= cmd.left_speed;
            count_reg[0] <= cmd.right_count[COUNT_BITS-1:0];
            count_reg[1] <= cmd.left_count[COUNT_BITS-1:0];
        end
        if (state_reg == ST_LOAD)
            delta_reg <= delta_calc;
        if (state_reg == ST_ERR)
            err_reg <= err_calc;
        if (state_reg == ST_INTG)
            acc_reg <= prod;
        if (state_reg == ST_SUM)
        begin
            duty_reg[wheel_reg] <= duty_calc;
            rev_reg[wheel_reg]  <= speed_cur[SPEED_W-1];
        end
        if (res_load)
        begin
            res_right_duty_reg <= duty_reg[0];
            res_left_duty_reg  <= duty_reg[1];
            res_right_rev_reg  <= rev_reg[0];
            res_left_rev_reg   <= rev_reg[1];
        end
    end

endmodule

>>> design/dual_wheel_pi_speed_control.sv
// a new request is taken only once the last result is handed over
// both wheels take five steps each, sharing the one multiplier,
//   plus one step to hand over the result
// a result waiting on the output holds the block in its last step until taken
// reset: gains, limit, scale to defaults; previous counts and sums clear to zero
// depends on dwpi_pkg, dwpi_cmd_if, dwpi_res_if, dwpi_cfg, dwpi_mul, dwpi_seq
module dual_wheel_pi_speed_control #(
    parameter int COUNT_BITS = dwpi_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dwpi_cmd_if.sink                         cmd,
    dwpi_res_if.source                       res,
    input  logic                             cfg_wr_en,
    input  logic [dwpi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dwpi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import dwpi_pkg::*;

    localparam int ERR_W  = COUNT_BITS + 2;
    localparam int PROD_W = ERR_W + SCALE_W + 1;

    cfg_t                     cfg;
    logic signed [ERR_W-1:0]  mul_a;
    logic [SCALE_W-1:0]       mul_b;
    logic signed [PROD_W-1:0] prod;

    dwpi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dwpi_mul #(
        .A_W    (ERR_W),
        .PROD_W (PROD_W)
    ) u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    dwpi_seq #(
        .COUNT_BITS (COUNT_BITS),
        .ERR_W      (ERR_W),
        .PROD_W     (PROD_W)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .res   (res),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

endmodule

>>> design/dwpi_chk.sv
// port-level checker for the dual wheel pi speed controller, bound to the top
// depends on dwpi_pkg and dual_wheel_pi_speed_control_macros.svh
`include "dual_wheel_pi_speed_control_macros.svh"

module dwpi_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [dwpi_pkg::DUTY_W-1:0]   res_right_duty,
    input logic [dwpi_pkg::DUTY_W-1:0]   res_left_duty,
    input logic                          res_right_reverse,
    input logic                          res_left_reverse
);
    import dwpi_pkg::*;

    // stalled result holds
    `DWPI_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_right_duty) && $stable(res_left_duty) && $stable(res_right_reverse) && $stable(res_left_reverse))

    // busy after a request is accepted
    `DWPI_ASSERT_NEXT(a_busy_after_req, cmd_valid && cmd_ready, !cmd_ready ##1 !cmd_ready)

    // a new result shows up exactly as the block frees up
    `DWPI_ASSERT_NOW(a_res_with_ready, $rose(res_valid), $rose(cmd_ready))

endmodule

bind dual_wheel_pi_speed_control dwpi_chk u_dwpi_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_right_duty    (res.right_duty),
    .res_left_duty     (res.left_duty),
    .res_right_reverse (res.right_reverse),
    .res_left_reverse  (res.left_reverse)
);

>>> tb/dual_wheel_pi_speed_control_test.sv
`timescale 1ns / 100ps
// self-checking testbench for dual_wheel_pi_speed_control: directed table, then random ticks
// per register setting, checked against an in-bench predictor of duty and direction
// depends on dwpi_pkg, dwpi_cmd_if, dwpi_res_if and the block itself
module dual_wheel_pi_speed_control_test;
    import dwpi_pkg::*;

    localparam int     CYCLE_LIMIT = 400000;
    localparam int     LONG_HOLD   = 300;
    localparam longint FRAC_SCALE  = longint'(1) << FRAC_BITS;

    typedef struct packed {
        logic [DUTY_W-1:0] right_duty;
        logic [DUTY_W-1:0] left_duty;
        logic              right_reverse;
        logic              left_reverse;
    } duty_result_t;

    typedef struct {
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [COUNT_W-1:0] right_count;
        logic signed [COUNT_W-1:0] left_count;
        bit                        known;
        duty_result_t              want;
    } request_row_t;

    typedef struct {
        bit                    write_regs;
        bit                    rand_regs;
        logic [CFG_DATA_W-1:0] prop_gain;
        logic [CFG_DATA_W-1:0] integral_gain;
        logic [CFG_DATA_W-1:0] integral_limit;
        logic [CFG_DATA_W-1:0] count_scale;
        bit                    idle;
        int                    items;
    } gain_phase_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    dwpi_cmd_if cmd_ch ();
    dwpi_res_if res_ch ();

    dual_wheel_pi_speed_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    cfg_t                      model_cfg;
    logic signed [COUNT_W-1:0] last_count_r;
    logic signed [COUNT_W-1:0] last_count_l;
    longint                    err_sum_r;
    longint                    err_sum_l;
    logic signed [COUNT_W-1:0] sent_count_r;
    logic signed [COUNT_W-1:0] sent_count_l;
    duty_result_t              expected_duties[$];
    int                        mismatch_count = 0;
    int                        cycle_count = 0;
    bit                        idling_on = 1'b0;
    bit                        long_hold_req = 1'b0;

    logic signed [SPEED_W-1:0] corner_speeds[7] =
        '{11'sd0, FORCE_ZERO_SPEED, -11'sd320, 11'sd1023, -11'sd1024, 11'sd1, -11'sd1};

    request_row_t directed_rows[15] = '{
        '{11'sd0,     11'sd0,     32'sd0,          32'sd0,          1'b1, '{12'd0, 12'd0, 1'b0, 1'b0}},
        '{11'sd1023,  -11'sd1024, 32'sd0,          32'sd0,          1'b1, '{12'd1325, 12'd0, 1'b0, 1'b1}},
        '{11'sd320,   11'sd320,   32'sd0,          32'sd0,          1'b1, '{12'd0, 12'd0, 1'b0, 1'b0}},
        '{11'sd100,   11'sd100,   32'sh7FFF_FFFF,  32'sh8000_0000,  1'b1, '{12'd0, 12'd4095, 1'b0, 1'b0}},
        '{-11'sd1,    11'sd1,     32'sh8000_0000,  32'sh7FFF_FFFF,  1'b0, '0},
        '{11'sd0,     11'sd0,     32'sh1234_5678,  -32'sd5,         1'b1, '{12'd0, 12'd0, 1'b0, 1'b0}},
        '{-11'sd320,  11'sd319,   32'sh1234_5600,  32'sd0,          1'b0, '0},
        '{11'sd321,   -11'sd1024, 32'sh1234_5800,  -32'sd40,        1'b0, '0},
        '{-11'sd1024, 11'sd1023,  32'sh1234_5700,  32'sd25,         1'b0, '0},
        '{11'sd512,   -11'sd512,  32'sh1234_570C,  32'sd12,         1'b0, '0},
        '{11'sd1,     -11'sd1,    32'sh1234_570C,  32'sd12,         1'b0, '0},
        '{11'sd1023,  11'sd1023,  32'shFFFF_FFFF,  32'sd0,          1'b0, '0},
        '{-11'sd1024, -11'sd1024, 32'sd0,          32'shFFFF_FFFF,  1'b0, '0},
        '{11'sd320,   -11'sd320,  32'sh5555_5555,  32'shAAAA_AAAA,  1'b0, '0},
        '{11'sd0,     11'sd0,     32'sh0000_0007,  32'shAAAA_AAA0,  1'b1, '{12'd0, 12'd0, 1'b0, 1'b0}}
    };

    gain_phase_t phases[8] = '{
        '{1'b0, 1'b0, 16'd50,    16'd3,     16'd500,   16'd25752, 1'b1, 250},
        '{1'b1, 1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     1'b1, 150},
        '{1'b1, 1'b0, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, 200},
        '{1'b1, 1'b0, 16'd300,   16'd255,   16'd4095,  16'd65535, 1'b1, 250},
        '{1'b1, 1'b0, 16'd1,     16'd1,     16'd0,     16'd25752, 1'b1, 200},
        '{1'b1, 1'b1, 16'd0,     16'd0,     16'd0,     16'd0,     1'b1, 250},
        '{1'b1, 1'b1, 16'd0,     16'd0,     16'd0,     16'd0,     1'b1, 250},
        '{1'b1, 1'b0, 16'd50,    16'd3,     16'd500,   16'd25752, 1'b0, 300}
    };

    function automatic void wheel_drive(
        input  logic signed [SPEED_W-1:0] speed,
        input  logic signed [COUNT_W-1:0] count,
        inout  logic signed [COUNT_W-1:0] last_count,
        inout  longint                    err_sum,
        output logic [DUTY_W-1:0]         duty,
        output logic                      reverse
    );
        logic signed [COUNT_W-1:0] moved;
        longint err;
        longint lim;
        longint drive;
        moved = count - last_count;
        err = (longint'(speed) * longint'(model_cfg.count_scale)
               - longint'(moved) * FRAC_SCALE) / FRAC_SCALE;
        lim = longint'(model_cfg.integral_limit);
        last_count = count;
        err_sum = err_sum + err;
        if (err_sum > lim)
            err_sum = lim;
        if (err_sum < -lim)
            err_sum = -lim;
        drive = longint'(model_cfg.prop_gain) * err
                + longint'(model_cfg.integral_gain) * err_sum;
        if (speed == FORCE_ZERO_SPEED)
            drive = 0;
        if (drive < 0)
            drive = 0;
        if (drive > PWM_MAX)
            drive = PWM_MAX;
        if (speed == 0)
            drive = 0;
        duty = drive[DUTY_W-1:0];
        reverse = (speed < 0);
    endfunction

    function automatic duty_result_t predict_duties(
        input logic signed [SPEED_W-1:0] rs,
        input logic signed [SPEED_W-1:0] ls,
        input logic signed [COUNT_W-1:0] rc,
        input logic signed [COUNT_W-1:0] lc
    );
        duty_result_t r;
        wheel_drive(rs, rc, last_count_r, err_sum_r, r.right_duty, r.right_reverse);
        wheel_drive(ls, lc, last_count_l, err_sum_l, r.left_duty, r.left_reverse);
        return r;
    endfunction

    function automatic logic signed [SPEED_W-1:0] random_speed();
        if ($urandom_range(0, 7) == 0)
            return corner_speeds[$urandom_range(0, 6)];
        return SPEED_W'($urandom);
    endfunction

    // mostly counts that follow the command, some drift and some jumps
    function automatic logic signed [COUNT_W-1:0] next_count(
        input logic signed [SPEED_W-1:0] speed,
        input logic signed [COUNT_W-1:0] last
    );
        int unsigned pick;
        longint      step;
        longint      jitter;
        pick = $urandom_range(0, 19);
        step = longint'(speed) * longint'(model_cfg.count_scale) / FRAC_SCALE;
        if (pick < 14)
        begin
            jitter = longint'($urandom_range(0, 12)) - 6;
            return last + COUNT_W'(step + jitter);
        end
        if (pick < 17)
        begin
            jitter = longint'($urandom_range(0, 600)) - 300;
            return last + COUNT_W'(jitter);
        end
        return COUNT_W'($urandom);
    endfunction

    task automatic log_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic send_request(
        input logic signed [SPEED_W-1:0] rs,
        input logic signed [SPEED_W-1:0] ls,
        input logic signed [COUNT_W-1:0] rc,
        input logic signed [COUNT_W-1:0] lc,
        input bit                        known,
        input duty_result_t              want
    );
        duty_result_t predicted;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.right_speed <= rs;
        cmd_ch.left_speed  <= ls;
        cmd_ch.right_count <= rc;
        cmd_ch.left_count  <= lc;
        sent_count_r = rc;
        sent_count_l = lc;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        predicted = predict_duties(rs, ls, rc, lc);
        expected_duties.push_back(known ? want : predicted);
    endtask

    task automatic idle_gap();
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_duties.size() != 0);
    endtask

    task automatic program_registers(input gain_phase_t ph);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PROP_GAIN;
        cfg_wdata <= ph.prop_gain;
        @(posedge clk);
        cfg_index <= REG_INTEGRAL_GAIN;
        cfg_wdata <= ph.integral_gain;
        @(posedge clk);
        cfg_index <= REG_INTEGRAL_LIMIT;
        cfg_wdata <= ph.integral_limit;
        @(posedge clk);
        cfg_index <= REG_COUNT_SCALE;
        cfg_wdata <= ph.count_scale;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_cfg.prop_gain      = ph.prop_gain[PGAIN_W-1:0];
        model_cfg.integral_gain  = ph.integral_gain[IGAIN_W-1:0];
        model_cfg.integral_limit = ph.integral_limit[LIMIT_W-1:0];
        model_cfg.count_scale    = ph.count_scale[SCALE_W-1:0];
    endtask

    initial
    begin : request_source
        logic signed [SPEED_W-1:0] rs;
        logic signed [SPEED_W-1:0] ls;
        logic signed [COUNT_W-1:0] rc;
        logic signed [COUNT_W-1:0] lc;
        gain_phase_t               ph;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = REG_PROP_GAIN;
        cfg_wdata          = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.right_speed = '0;
        cmd_ch.left_speed  = '0;
        cmd_ch.right_count = '0;
        cmd_ch.left_count  = '0;
        model_cfg = '{PGAIN_RST, IGAIN_RST, LIMIT_RST, SCALE_RST};
        last_count_r = '0;
        last_count_l = '0;
        err_sum_r    = 0;
        err_sum_l    = 0;
        sent_count_r = '0;
        sent_count_l = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idling_on = 1'b1;
        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].right_speed, directed_rows[i].left_speed,
                         directed_rows[i].right_count, directed_rows[i].left_count,
                         directed_rows[i].known, directed_rows[i].want);
            idle_gap();
        end
        foreach (phases[p])
        begin
            ph = phases[p];
            drain();
            if (ph.rand_regs)
            begin
                ph.prop_gain      = CFG_DATA_W'($urandom_range(0, 300));
                ph.integral_gain  = CFG_DATA_W'($urandom_range(0, 255));
                ph.integral_limit = CFG_DATA_W'($urandom_range(0, 4095));
                ph.count_scale    = CFG_DATA_W'($urandom_range(0, 65535));
            end
            if (ph.write_regs)
                program_registers(ph);
            idling_on = ph.idle;
            for (int n = 0; n < ph.items; n++)
            begin
                // receiver backs off while requests keep coming
                if (p == 0 && n == 100)
                    long_hold_req = 1'b1;
                if (p == 0 && n == 180)
                    drain();
                rs = random_speed();
                ls = random_speed();
                rc = next_count(rs, sent_count_r);
                lc = next_count(ls, sent_count_l);
                send_request(rs, ls, rc, lc, 1'b0, '0);
                idle_gap();
            end
        end
        drain();
        repeat (24) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left == 0 && stall_left == 0 && idling_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 7);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        duty_result_t want;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (expected_duties.size() == 0)
                log_mismatch("result with no request pending", 0, res_ch.right_duty);
            else
            begin
                want = expected_duties.pop_front();
                if (res_ch.right_duty !== want.right_duty)
                    log_mismatch("right_duty", want.right_duty, res_ch.right_duty);
                if (res_ch.left_duty !== want.left_duty)
                    log_mismatch("left_duty", want.left_duty, res_ch.left_duty);
                if (res_ch.right_reverse !== want.right_reverse)
                    log_mismatch("right_reverse", want.right_reverse, res_ch.right_reverse);
                if (res_ch.left_reverse !== want.left_reverse)
                    log_mismatch("left_reverse", want.left_reverse, res_ch.left_reverse);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
